FILE: rtl/lrs_pkg.sv
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared types and constants of the serpentine matrix line rasterizer.
// ----------------------------------------------------------------------------
package lrs_pkg;

    localparam int IN_W       = 10;
    localparam int COLOR_W    = 8;
    localparam int IDX_W      = 10;
    localparam int GRB_W      = 24;
    localparam int GRID_W     = 6;
    localparam int ERR_W      = 14;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_GRID_LENGTH = 1'd1;

    localparam logic [GRID_W-1:0] GRID_WIDTH_RESET  = 6'd8;
    localparam logic [GRID_W-1:0] GRID_LENGTH_RESET = 6'd8;

    typedef struct packed {
        logic load;
        logic swap;
        logic order;
        logic init;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/lrs_cfg.sv
// ----------------------------------------------------------------------------
// lrs_cfg
// Register file for the grid size, written and read over the APB port.
// ----------------------------------------------------------------------------
module lrs_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lrs_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [lrs_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [lrs_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [lrs_pkg::GRID_W-1:0]       grid_width,
    output logic [lrs_pkg::GRID_W-1:0]       grid_length
);
    import lrs_pkg::*;

    logic [GRID_W-1:0]    width_reg;
    logic [GRID_W-1:0]    width_next;
    logic [GRID_W-1:0]    length_reg;
    logic [GRID_W-1:0]    length_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        width_next  = width_reg;
        length_next = length_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_GRID_WIDTH:  width_next  = pwdata[GRID_W-1:0];
                REG_GRID_LENGTH: length_next = pwdata[GRID_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GRID_WIDTH:  prdata = CFG_DATA_W'(width_reg);
            REG_GRID_LENGTH: prdata = CFG_DATA_W'(length_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= GRID_WIDTH_RESET;
            length_reg <= GRID_LENGTH_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            length_reg <= length_next;
        end
    end

    assign grid_width  = width_reg;
    assign grid_length = length_reg;

endmodule

FILE: rtl/lrs_ctrl.sv
// ----------------------------------------------------------------------------
// lrs_ctrl
// Sequencer: takes a line command, runs the setup steps, then steps pixels.
// ----------------------------------------------------------------------------
module lrs_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  lrs_pkg::dp_status_t   status,
    output lrs_pkg::dp_cmd_t      cmd
);
    import lrs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWAP,
        ST_ORDER,
        ST_INIT,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = accept;
                if (accept)
                begin
                    state_next = ST_SWAP;
                end
            end
            ST_SWAP:
            begin
                cmd.swap   = 1'b1;
                state_next = ST_ORDER;
            end
            ST_ORDER:
            begin
                cmd.order  = 1'b1;
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                cmd.step = status.out_free;
                if (status.out_free && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_starts_setup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_SWAP)
        else $error("line transfer did not start setup");

    a_run_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && !status.out_free) |=> state_reg == ST_RUN)
        else $error("pixel loop left while output blocked");

endmodule

FILE: rtl/lrs_dp.sv
// ----------------------------------------------------------------------------
// lrs_dp
// Datapath: endpoint setup, Bresenham stepping, grid clip, serpentine index
// and the output register.
// ----------------------------------------------------------------------------
module lrs_dp
#(
    parameter int MAX_SIDE        = 32,
    parameter int COORD_FRAC_BITS = 4
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  lrs_pkg::dp_cmd_t                    cmd,
    output lrs_pkg::dp_status_t                 status,
    input  logic [lrs_pkg::GRID_W-1:0]          grid_width,
    input  logic [lrs_pkg::GRID_W-1:0]          grid_length,
    input  logic signed [lrs_pkg::IN_W-1:0]     start_x,
    input  logic signed [lrs_pkg::IN_W-1:0]     start_y,
    input  logic signed [lrs_pkg::IN_W-1:0]     end_x,
    input  logic signed [lrs_pkg::IN_W-1:0]     end_y,
    input  logic [lrs_pkg::COLOR_W-1:0]         red,
    input  logic [lrs_pkg::COLOR_W-1:0]         green,
    input  logic [lrs_pkg::COLOR_W-1:0]         blue,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [lrs_pkg::IDX_W-1:0]           led_index,
    output logic [lrs_pkg::GRB_W-1:0]           grb_word,
    output logic                                pixel_written,
    output logic                                last_pixel
);
    import lrs_pkg::*;

    localparam int CW    = IN_W + 1;
    localparam int DW    = CW + 1;
    localparam int MAJ_W = CW - COORD_FRAC_BITS + 1;
    localparam int CNT_W = $clog2(2 * MAX_SIDE);
    localparam int CMP_W = 16;
    localparam logic signed [CW-1:0] HALF      = CW'(2 ** (COORD_FRAC_BITS - 1));
    localparam logic [CNT_W-1:0]     STEP_CAP  = CNT_W'(2 * MAX_SIDE - 1);

    function automatic logic signed [MAJ_W-1:0] trunc_zero(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] q;
        logic                 adj;
        q   = v >>> COORD_FRAC_BITS;
        adj = v[CW-1] && (v[COORD_FRAC_BITS-1:0] != '0);
        return MAJ_W'(q) + MAJ_W'(adj);
    endfunction

    // endpoint registers, major/minor after the swap step
    logic signed [CW-1:0]    a_maj_reg, a_maj_next;
    logic signed [CW-1:0]    a_min_reg, a_min_next;
    logic signed [CW-1:0]    b_maj_reg, b_maj_next;
    logic signed [CW-1:0]    b_min_reg, b_min_next;
    logic [GRB_W-1:0]        grb_reg, grb_next;
    logic                    steep_reg, steep_next;
    logic                    yup_reg, yup_next;
    logic signed [ERR_W-1:0] dx2_reg, dx2_next;
    logic signed [ERR_W-1:0] dy2_reg, dy2_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic signed [MAJ_W-1:0] major_reg, major_next;
    logic signed [MAJ_W-1:0] minor_reg, minor_next;
    logic signed [MAJ_W-1:0] end_reg, end_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        base_reg, base_next;

    logic                    out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]        led_index_reg, led_index_next;
    logic [GRB_W-1:0]        grb_word_reg, grb_word_next;
    logic                    written_reg, written_next;
    logic                    last_reg, last_next;

    logic signed [DW-1:0]    d_maj, d_min, abs_maj, abs_min;
    logic signed [ERR_W-1:0] err_sub;
    logic [2*GRID_W-1:0]     area;
    logic signed [MAJ_W-1:0] px, py;
    logic signed [CMP_W-1:0] px_c, py_c, w_hi, w_lo, l_hi, l_lo;
    logic                    in_grid;
    logic [IDX_W-1:0]        x10, y10, w10;
    logic [2*IDX_W-1:0]      xw_full;
    logic [IDX_W-1:0]        pix_index;
    logic                    last_step;

    assign last_step       = (major_reg == end_reg) || (count_reg == STEP_CAP);
    assign status.last     = last_step;
    assign status.out_free = !out_valid_reg || !out_stall;

    // pixel position, clip test and serpentine index
    always_comb
    begin
        px      = steep_reg ? minor_reg : major_reg;
        py      = steep_reg ? major_reg : minor_reg;
        px_c    = CMP_W'(px);
        py_c    = CMP_W'(py);
        w_hi    = CMP_W'(grid_width >> 1);
        w_lo    = CMP_W'(1) - w_hi;
        l_hi    = CMP_W'(grid_length >> 1);
        l_lo    = CMP_W'(1) - l_hi;
        in_grid = (py_c <= w_hi) && (py_c >= w_lo) && (px_c <= l_hi) && (px_c >= l_lo);
        x10     = IDX_W'(px);
        y10     = IDX_W'(py);
        w10     = IDX_W'(grid_width);
        xw_full = x10 * w10;
        if (px[0])
        begin
            pix_index = base_reg + xw_full[IDX_W-1:0] - y10 + IDX_W'(1);
        end
        else
        begin
            pix_index = base_reg + xw_full[IDX_W-1:0] + y10;
        end
    end

    always_comb
    begin
        a_maj_next = a_maj_reg;
        a_min_next = a_min_reg;
        b_maj_next = b_maj_reg;
        b_min_next = b_min_reg;
        grb_next   = grb_reg;
        steep_next = steep_reg;
        yup_next   = yup_reg;
        dx2_next   = dx2_reg;
        dy2_next   = dy2_reg;
        err_next   = err_reg;
        major_next = major_reg;
        minor_next = minor_reg;
        end_next   = end_reg;
        count_next = count_reg;
        base_next  = base_reg;

        d_maj   = DW'(b_maj_reg) - DW'(a_maj_reg);
        d_min   = DW'(b_min_reg) - DW'(a_min_reg);
        abs_maj = d_maj[DW-1] ? -d_maj : d_maj;
        abs_min = d_min[DW-1] ? -d_min : d_min;
        err_sub = err_reg - dy2_reg;
        area    = grid_width * grid_length;

        if (cmd.load)
        begin
            a_maj_next = CW'(start_x) + HALF;
            a_min_next = CW'(start_y) + HALF;
            b_maj_next = CW'(end_x) + HALF;
            b_min_next = CW'(end_y) + HALF;
            grb_next   = {green, red, blue};
        end

        // steep line: minor span beats major span, exchange the axes
        if (cmd.swap)
        begin
            steep_next = abs_min > abs_maj;
            if (abs_min > abs_maj)
            begin
                a_maj_next = a_min_reg;
                a_min_next = a_maj_reg;
                b_maj_next = b_min_reg;
                b_min_next = b_maj_reg;
            end
        end

        if (cmd.order)
        begin
            if (a_maj_reg > b_maj_reg)
            begin
                a_maj_next = b_maj_reg;
                a_min_next = b_min_reg;
                b_maj_next = a_maj_reg;
                b_min_next = a_min_reg;
            end
        end

        if (cmd.init)
        begin
            dx2_next   = ERR_W'(d_maj) <<< 1;
            dy2_next   = ERR_W'(abs_min) <<< 1;
            err_next   = ERR_W'(d_maj);
            yup_next   = a_min_reg < b_min_reg;
            major_next = trunc_zero(a_maj_reg);
            minor_next = trunc_zero(a_min_reg);
            end_next   = trunc_zero(b_maj_reg);
            count_next = '0;
            base_next  = IDX_W'(area >> 1) - IDX_W'(grid_width >> 1) - IDX_W'(1);
        end

        if (cmd.step)
        begin
            major_next = major_reg + MAJ_W'(1);
            count_next = count_reg + CNT_W'(1);
            if (err_sub < 0)
            begin
                minor_next = minor_reg + (yup_reg ? MAJ_W'(1) : '1);
                err_next   = err_sub + dx2_reg;
            end
            else
            begin
                err_next = err_sub;
            end
        end
    end

    // output register
    always_comb
    begin
        led_index_next = led_index_reg;
        grb_word_next  = grb_word_reg;
        written_next   = written_reg;
        last_next      = last_reg;
        if (cmd.step)
        begin
            out_valid_next = 1'b1;
            led_index_next = in_grid ? pix_index : '0;
            grb_word_next  = grb_reg;
            written_next   = in_grid;
            last_next      = last_step;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_maj_reg     <= a_maj_next;
        a_min_reg     <= a_min_next;
        b_maj_reg     <= b_maj_next;
        b_min_reg     <= b_min_next;
        grb_reg       <= grb_next;
        steep_reg     <= steep_next;
        yup_reg       <= yup_next;
        dx2_reg       <= dx2_next;
        dy2_reg       <= dy2_next;
        err_reg       <= err_next;
        major_reg     <= major_next;
        minor_reg     <= minor_next;
        end_reg       <= end_next;
        count_reg     <= count_next;
        base_reg      <= base_next;
        led_index_reg <= led_index_next;
        grb_word_reg  <= grb_word_next;
        written_reg   <= written_next;
        last_reg      <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign led_index     = led_index_reg;
    assign grb_word      = grb_word_reg;
    assign pixel_written = written_reg;
    assign last_pixel    = last_reg;

    a_major_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> major_reg <= end_reg)
        else $error("major coordinate stepped past line end");

    a_clipped_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !written_reg) |-> led_index_reg == '0)
        else $error("clipped pixel carries an index");

    a_step_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && out_valid_reg) |-> !out_stall)
        else $error("pixel overwrote a waiting transfer");

endmodule

FILE: rtl/line_rasterizer_serpentine_matrix.sv
// ----------------------------------------------------------------------------
// line_rasterizer_serpentine_matrix
// Bresenham line rasterizer mapping each step onto a serpentine LED matrix.
//
//   channel   direction  handshake          payload
//   in        sink       in_valid/in_stall  start_x start_y end_x end_y red green blue
//   out       source     out_valid/out_stall led_index grb_word pixel_written last_pixel
//   cfg       sink       APB                grid_width @0x0, grid_length @0x4
//
// a line runs the setup steps (capture, axis swap, endpoint order, init), then
// one pixel per cycle from the stepping unit unless stalled, n = 1 to 2*MAX_SIDE pixels
// one line in flight at a time; the next is taken once its last pixel is stepped
// output stall freezes the pixel loop; a finished pixel waits in the output register
// reset: idle, grid 8 by 8, no clearing pass
// ----------------------------------------------------------------------------
module line_rasterizer_serpentine_matrix
#(
    parameter int MAX_SIDE        = 32,
    parameter int COORD_FRAC_BITS = 4
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [lrs_pkg::IN_W-1:0]     start_x,
    input  logic signed [lrs_pkg::IN_W-1:0]     start_y,
    input  logic signed [lrs_pkg::IN_W-1:0]     end_x,
    input  logic signed [lrs_pkg::IN_W-1:0]     end_y,
    input  logic [lrs_pkg::COLOR_W-1:0]         red,
    input  logic [lrs_pkg::COLOR_W-1:0]         green,
    input  logic [lrs_pkg::COLOR_W-1:0]         blue,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lrs_pkg::IDX_W-1:0]           led_index,
    output logic [lrs_pkg::GRB_W-1:0]           grb_word,
    output logic                                pixel_written,
    output logic                                last_pixel,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lrs_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [lrs_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [lrs_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import lrs_pkg::*;

    dp_cmd_t           cmd;
    dp_status_t        status;
    logic [GRID_W-1:0] grid_width;
    logic [GRID_W-1:0] grid_length;

    lrs_cfg u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .grid_width  (grid_width),
        .grid_length (grid_length)
    );

    lrs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    lrs_dp
    #(
        .MAX_SIDE        (MAX_SIDE),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .grid_width    (grid_width),
        .grid_length   (grid_length),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .led_index     (led_index),
        .grb_word      (grb_word),
        .pixel_written (pixel_written),
        .last_pixel    (last_pixel)
    );

endmodule
